// ===== design/cht_pkg.sv =====
// Shared types and constants for the cuckoo hash table unit.
package cht_pkg;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned SLOT_W  = 13;
    localparam int unsigned ENTRY_W = KEY_W + VAL_W;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [6:0] {
        ST_CLEAR     = 7'b0000001,
        ST_IDLE      = 7'b0000010,
        ST_LK_FIRST  = 7'b0000100,
        ST_LK_CMP1   = 7'b0001000,
        ST_LK_CMP2   = 7'b0010000,
        ST_INS_READ  = 7'b0100000,
        ST_INS_WRITE = 7'b1000000
    } cht_state_t;

    typedef enum logic [1:0] {
        RD_FIRST  = 2'd0,
        RD_SECOND = 2'd1,
        RD_SLOT   = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        rd_sel_t rd_sel;
        logic    mem_wr;
        logic    clear_wr;
        logic    advance;
        logic    res_valid;
        logic    res_lookup;
        logic    res_ovf;
    } cht_cmd_t;

    typedef struct packed {
        logic in_key_zero;
        logic match;
        logic old_empty;
        logic clear_last;
    } cht_status_t;

endpackage

// ===== design/cht_datapath.sv =====
// Datapath of the cuckoo hash table: pair registers, slot hashing, table memory, result registers.
module cht_datapath
    import cht_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES     = 8192,
    parameter int unsigned SECOND_HASH_SHIFT = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [KEY_W-1:0]   key,
    input  logic [VAL_W-1:0]   value,
    input  cht_cmd_t           cmd,
    output cht_status_t        status,
    output logic               strobe,
    output logic               hit,
    output logic [VAL_W-1:0]   found_value,
    output logic               insert_overflow
);

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);

    function automatic logic [AW-1:0] reduce_slot(input logic [SLOT_W-1:0] raw);
        logic [31:0] r;
        r = 32'(raw);
        if (r >= 32'(4 * TABLE_ENTRIES))
        begin
            r = r - 32'(4 * TABLE_ENTRIES);
        end
        if (r >= 32'(2 * TABLE_ENTRIES))
        begin
            r = r - 32'(2 * TABLE_ENTRIES);
        end
        if (r >= 32'(TABLE_ENTRIES))
        begin
            r = r - 32'(TABLE_ENTRIES);
        end
        return AW'(r);
    endfunction

    function automatic logic [AW-1:0] first_slot(input logic [KEY_W-1:0] k);
        return reduce_slot(k[SLOT_W-1:0]);
    endfunction

    function automatic logic [AW-1:0] second_slot(input logic [KEY_W-1:0] k);
        return reduce_slot(SLOT_W'(k >> SECOND_HASH_SHIFT));
    endfunction

    logic [ENTRY_W-1:0] table_mem [TABLE_ENTRIES];

    logic [KEY_W-1:0]   key_reg,      key_next;
    logic [VAL_W-1:0]   val_reg,      val_next;
    logic [AW-1:0]      slot_reg,     slot_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [ENTRY_W-1:0] rd_entry_reg;
    logic               strobe_reg,   strobe_next;
    logic               hit_reg,      hit_next;
    logic [VAL_W-1:0]   fv_reg,       fv_next;
    logic               ovf_reg,      ovf_next;

    logic [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]   rd_val;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               wr_en;
    logic [AW-1:0]      old_first;

    assign rd_key    = rd_entry_reg[ENTRY_W-1:VAL_W];
    assign rd_val    = rd_entry_reg[VAL_W-1:0];
    assign old_first = first_slot(rd_key);

    assign status.in_key_zero = (key == '0);
    assign status.match       = (rd_key == key_reg);
    assign status.old_empty   = (rd_key == '0);
    assign status.clear_last  = (clr_addr_reg == AW'(TABLE_ENTRIES - 1));

    always_comb
    begin
        case (cmd.rd_sel)
            RD_FIRST:  rd_addr = first_slot(key_reg);
            RD_SECOND: rd_addr = second_slot(key_reg);
            RD_SLOT:   rd_addr = slot_reg;
            default:   rd_addr = slot_reg;
        endcase
    end

    assign wr_en   = cmd.mem_wr | cmd.clear_wr;
    assign wr_addr = cmd.clear_wr ? clr_addr_reg : slot_reg;
    assign wr_data = cmd.clear_wr ? '0 : {key_reg, val_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_entry_reg <= table_mem[rd_addr];
    end

    always_comb
    begin
        key_next      = key_reg;
        val_next      = val_reg;
        slot_next     = slot_reg;
        clr_addr_next = clr_addr_reg;
        if (cmd.load)
        begin
            key_next  = key;
            val_next  = value;
            slot_next = first_slot(key);
        end
        else if (cmd.advance)
        begin
            key_next  = rd_key;
            val_next  = rd_val;
            slot_next = (slot_reg == old_first) ? second_slot(rd_key) : old_first;
        end
        if (cmd.clear_wr)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end
    end

    always_comb
    begin
        strobe_next = cmd.res_valid;
        hit_next    = hit_reg;
        fv_next     = fv_reg;
        ovf_next    = ovf_reg;
        if (cmd.res_valid)
        begin
            hit_next = cmd.res_lookup & status.match;
            fv_next  = (cmd.res_lookup & status.match) ? rd_val : '0;
            ovf_next = cmd.res_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        val_reg  <= val_next;
        slot_reg <= slot_next;
        hit_reg  <= hit_next;
        fv_reg   <= fv_next;
        ovf_reg  <= ovf_next;
    end

    assign strobe          = strobe_reg;
    assign hit             = hit_reg;
    assign found_value     = fv_reg;
    assign insert_overflow = ovf_reg;

endmodule

// ===== design/cht_controller.sv =====
// Controller of the cuckoo hash table: clearing sweep, lookup and eviction walk sequencing.
module cht_controller
    import cht_pkg::*;
#(
    parameter int unsigned MAX_KICKS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        req_type,
    input  cht_status_t status,
    output cht_cmd_t    cmd,
    output logic        busy
);

    localparam int unsigned KW = $clog2(MAX_KICKS + 1);

    cht_state_t      state_reg, state_next;
    logic [KW-1:0]   kick_reg,  kick_next;
    logic            last_kick;

    assign last_kick = (kick_reg == KW'(MAX_KICKS - 1));
    assign busy      = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        kick_next  = kick_reg;
        cmd        = '0;
        cmd.rd_sel = RD_SLOT;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (status.in_key_zero)
                    begin
                        cmd.res_valid = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        kick_next  = '0;
                        state_next = (req_type == REQ_LOOKUP) ? ST_LK_FIRST : ST_INS_READ;
                    end
                end
            end
            ST_LK_FIRST:
            begin
                cmd.rd_sel = RD_FIRST;
                state_next = ST_LK_CMP1;
            end
            ST_LK_CMP1:
            begin
                if (status.match)
                begin
                    cmd.res_valid  = 1'b1;
                    cmd.res_lookup = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_SECOND;
                    state_next = ST_LK_CMP2;
                end
            end
            ST_LK_CMP2:
            begin
                cmd.res_valid  = 1'b1;
                cmd.res_lookup = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_INS_READ:
            begin
                cmd.rd_sel = RD_SLOT;
                state_next = ST_INS_WRITE;
            end
            ST_INS_WRITE:
            begin
                cmd.mem_wr = 1'b1;
                if (status.old_empty)
                begin
                    cmd.res_valid = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (last_kick)
                begin
                    cmd.res_valid = 1'b1;
                    cmd.res_ovf   = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    kick_next   = kick_reg + 1'b1;
                    state_next  = ST_INS_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            kick_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kick_reg  <= kick_next;
        end
    end

endmodule

// ===== design/cuckoo_hash_table_unit.sv =====
// Top level of the two-choice cuckoo hash table unit.
//
// Requests enter on start/busy: an item (req_type, key, value) is taken at a
// rising edge with start high and busy low. Each item gives one result on
// hit, found_value and insert_overflow, shown for one cycle with strobe high;
// the receiver always takes it.
// Key zero is reserved: its result follows in the next cycle and the unit
// stays free, so such items may come every cycle.
// A lookup reads the first candidate slot and, on a mismatch, the second from
// the table memory, which has one read port and one write port.
// An insert reads and rewrites one slot per placement, in the states
// ST_INS_READ and ST_INS_WRITE, with at most MAX_KICKS placements per item.
// After reset the unit sweeps the table one entry per cycle to clear it, and
// busy stays high until the sweep has cleared the last entry.
module cuckoo_hash_table_unit
    import cht_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES     = 8192,
    parameter int unsigned SECOND_HASH_SHIFT = 16,
    parameter int unsigned MAX_KICKS         = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             req_type,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    output logic             strobe,
    output logic             hit,
    output logic [VAL_W-1:0] found_value,
    output logic             insert_overflow
);

    cht_cmd_t    cmd;
    cht_status_t status;

    cht_controller #(
        .MAX_KICKS (MAX_KICKS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    cht_datapath #(
        .TABLE_ENTRIES     (TABLE_ENTRIES),
        .SECOND_HASH_SHIFT (SECOND_HASH_SHIFT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .key             (key),
        .value           (value),
        .cmd             (cmd),
        .status          (status),
        .strobe          (strobe),
        .hit             (hit),
        .found_value     (found_value),
        .insert_overflow (insert_overflow)
    );

endmodule

// ===== design/cht_checker.sv =====
// Port-level checks for the cuckoo hash table unit and their binding.
module cht_checker
    import cht_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             req_type,
    input logic [KEY_W-1:0] key,
    input logic [VAL_W-1:0] value,
    input logic             strobe,
    input logic             hit,
    input logic [VAL_W-1:0] found_value,
    input logic             insert_overflow
);

    a_hit_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !(hit && insert_overflow))
        else $error("hit and overflow in one result");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !hit) |-> (found_value == '0))
        else $error("miss with non-zero value");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && key != '0) |=> busy)
        else $error("unit free after taking a non-reserved item");

    a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && key == '0) |=> (strobe && !hit && !insert_overflow))
        else $error("reserved key did not give an empty result");

    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> busy)
        else $error("unit free straight after reset");

endmodule

bind cuckoo_hash_table_unit cht_checker u_checker (.*);

// ===== test/cuckoo_hash_table_unit_check.sv =====
// Checker for the cuckoo hash table unit: table predictor and result comparison.
`timescale 1ns / 100ps

module cuckoo_hash_table_unit_check
    import cht_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES     = 8192,
    parameter int unsigned SECOND_HASH_SHIFT = 16,
    parameter int unsigned MAX_KICKS         = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             req_type,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    input  logic             strobe,
    input  logic             hit,
    input  logic [VAL_W-1:0] found_value,
    input  logic             insert_overflow,
    output int               mismatches,
    output int               outstanding
);

    localparam logic [KEY_W-1:0] SLOT_MASK   = 64'h1FFF;
    localparam int               PRINT_LIMIT = 100;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] found_value;
        logic             overflow;
    } lookup_result_t;

    bit [KEY_W-1:0] key_tbl [TABLE_ENTRIES];
    bit [VAL_W-1:0] val_tbl [TABLE_ENTRIES];

    lookup_result_t awaited_results [$];

    function automatic int unsigned first_slot(logic [KEY_W-1:0] k);
        return int'((k & SLOT_MASK) % TABLE_ENTRIES);
    endfunction

    function automatic int unsigned second_slot(logic [KEY_W-1:0] k);
        return int'(((k >> SECOND_HASH_SHIFT) & SLOT_MASK) % TABLE_ENTRIES);
    endfunction

    // Walk the eviction chain; returns 1 when a pair is dropped at the kick limit.
    function automatic logic place_pair(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        logic [KEY_W-1:0] old_k;
        logic [VAL_W-1:0] old_v;
        int unsigned      slot;
        slot = first_slot(k);
        for (int unsigned kicks = 1; kicks <= MAX_KICKS; kicks++)
        begin
            old_k = key_tbl[slot];
            old_v = val_tbl[slot];
            key_tbl[slot] = k;
            val_tbl[slot] = v;
            if (old_k == '0)
                return 1'b0;
            if (kicks >= MAX_KICKS)
                return 1'b1;
            k = old_k;
            v = old_v;
            slot = (slot == first_slot(k)) ? second_slot(k) : first_slot(k);
        end
        return 1'b1;
    endfunction

    function automatic lookup_result_t table_access(logic rt, logic [KEY_W-1:0] k,
                                                    logic [VAL_W-1:0] v);
        lookup_result_t res;
        int unsigned    slot;
        res = '0;
        if (k != '0)
        begin
            if (rt == REQ_INSERT)
                res.overflow = place_pair(k, v);
            else
            begin
                slot = first_slot(k);
                if (key_tbl[slot] != k)
                    slot = second_slot(k);
                if (key_tbl[slot] == k)
                begin
                    res.hit = 1'b1;
                    res.found_value = val_tbl[slot];
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (mismatches < PRINT_LIMIT)
            $display("check: %0t %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            mismatches = 0;
            outstanding <= 0;
            awaited_results.delete();
        end
        else
        begin
            if (strobe)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with no item pending, hit", hit, 0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", hit, want.hit);
                    if (found_value !== want.found_value)
                        report_mismatch("found_value", found_value, want.found_value);
                    if (insert_overflow !== want.overflow)
                        report_mismatch("insert_overflow", insert_overflow, want.overflow);
                end
            end
            if (start && !busy)
                awaited_results.push_back(table_access(req_type, key, value));
            outstanding <= awaited_results.size();
        end
    end

endmodule

// ===== test/cuckoo_hash_table_unit_test.sv =====
// Top of the cuckoo hash table unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module cuckoo_hash_table_unit_test;
    import cht_pkg::*;

    localparam int unsigned MAX_KICKS   = 64;
    localparam int          ITEM_COUNT  = 1800;
    localparam int          CALM_FIRST  = 600;
    localparam int          CALM_LAST   = 950;
    localparam int          POOL_DEPTH  = 400;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             req_type = REQ_INSERT;
    logic [KEY_W-1:0] key = '0;
    logic [VAL_W-1:0] value = '0;
    logic             strobe;
    logic             hit;
    logic [VAL_W-1:0] found_value;
    logic             insert_overflow;
    int               mismatches;
    int               outstanding;

    logic [KEY_W-1:0] known_keys [$];

    cuckoo_hash_table_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .key             (key),
        .value           (value),
        .strobe          (strobe),
        .hit             (hit),
        .found_value     (found_value),
        .insert_overflow (insert_overflow)
    );

    cuckoo_hash_table_unit_check checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .key             (key),
        .value           (value),
        .strobe          (strobe),
        .hit             (hit),
        .found_value     (found_value),
        .insert_overflow (insert_overflow),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #12ms;
        $display("tb: failure");
        $finish;
    end

    task automatic send_item(logic rt, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        start    <= 1'b1;
        req_type <= rt;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (rt == REQ_INSERT && k != '0)
        begin
            known_keys.push_back(k);
            if (known_keys.size() > POOL_DEPTH)
                void'(known_keys.pop_front());
        end
    endtask

    // Hold the request line low for random idle cycles with junk on the fields.
    task automatic idle_gaps();
        while ($urandom_range(99) < 20)
        begin
            start    <= 1'b0;
            req_type <= 1'($urandom_range(1));
            key      <= {$urandom, $urandom};
            value    <= 16'($urandom_range(16'hFFFF));
            @(posedge clk);
        end
    endtask

    function automatic logic [KEY_W-1:0] craft_key(int unsigned s1, int unsigned s2);
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        k[12:0]  = s1[12:0];
        k[28:16] = s2[12:0];
        if (k == '0)
            k[KEY_W-1] = 1'b1;
        return k;
    endfunction

    initial
    begin
        int unsigned      pick;
        int unsigned      base;
        logic             rt;
        logic [KEY_W-1:0] k;
        int unsigned      s;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(REQ_LOOKUP, '1, 16'h0000);
        send_item(REQ_INSERT, '0, 16'hFFFF);
        send_item(REQ_LOOKUP, '0, 16'h0000);
        send_item(REQ_INSERT, '0, 16'h0000);
        send_item(REQ_INSERT, '1, 16'hFFFF);
        send_item(REQ_LOOKUP, '1, 16'h0000);
        send_item(REQ_INSERT, '1, 16'h1234);
        send_item(REQ_LOOKUP, '1, 16'h0000);
        send_item(REQ_INSERT, 64'h1, 16'h0000);
        send_item(REQ_LOOKUP, 64'h1, 16'hFFFF);
        send_item(REQ_INSERT, 64'h0000_0000_0009_0005, 16'h1111);
        send_item(REQ_INSERT, 64'h0000_0001_0003_0005, 16'h2222);
        send_item(REQ_LOOKUP, 64'h0000_0000_0009_0005, 16'h0000);
        send_item(REQ_LOOKUP, 64'h0000_0001_0003_0005, 16'h0000);
        send_item(REQ_INSERT, 64'h0000_0000_0064_0064, 16'h3333);
        send_item(REQ_INSERT, 64'h0000_0100_0064_0064, 16'h4444);
        send_item(REQ_LOOKUP, 64'h0000_0000_0064_0064, 16'h0000);
        send_item(REQ_LOOKUP, 64'h0000_0100_0064_0064, 16'h0000);
        send_item(REQ_INSERT, 64'h8000_0000_0000_0000, 16'hAAAA);
        send_item(REQ_LOOKUP, 64'h8000_0000_0000_0000, 16'h0000);
        send_item(REQ_INSERT, 64'h0000_0000_1FFF_1FFF, 16'h5555);
        send_item(REQ_LOOKUP, 64'h0000_0000_1FFF_1FFF, 16'h0000);

        for (int n = 0; n < ITEM_COUNT; n++)
        begin
            if (n < CALM_FIRST || n > CALM_LAST)
                idle_gaps();
            base = ((n / 150) * 32) % 8192;
            rt = ($urandom_range(99) < 50) ? REQ_INSERT : REQ_LOOKUP;
            pick = $urandom_range(99);
            if (rt == REQ_INSERT)
            begin
                if (pick < 5)
                    k = '0;
                else if (pick < 20 && known_keys.size() > 0)
                    k = known_keys[$urandom_range(known_keys.size() - 1)];
                else if (pick < 55)
                    k = craft_key(base + $urandom_range(31), base + $urandom_range(31));
                else if (pick < 62)
                begin
                    s = $urandom_range(8191);
                    k = craft_key(s, s);
                end
                else
                    k = craft_key($urandom_range(8191), $urandom_range(8191));
            end
            else
            begin
                if (pick < 10)
                    k = '0;
                else if (pick < 65 && known_keys.size() > 0)
                    k = known_keys[$urandom_range(known_keys.size() - 1)];
                else if (pick < 85)
                    k = craft_key(base + $urandom_range(31), base + $urandom_range(31));
                else
                    k = craft_key($urandom_range(8191), $urandom_range(8191));
            end
            send_item(rt, k, 16'($urandom_range(16'hFFFF)));
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2 * MAX_KICKS + 8) @(posedge clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== cuckoo_hash_table_unit.f =====
design/cht_pkg.sv
design/cht_datapath.sv
design/cht_controller.sv
design/cuckoo_hash_table_unit.sv
design/cht_checker.sv
test/cuckoo_hash_table_unit_check.sv
test/cuckoo_hash_table_unit_test.sv
